FILE: rtl/scsr_pkg.sv
// Shared constants, types and helper functions for the sector cache
// tag and replacement block. No dependencies.
package scsr_pkg;

    localparam int ENTRIES           = 8;
    localparam int SECTORS_PER_ENTRY = 8;
    localparam int SCORE_BITS        = 16;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OFF_W   = $clog2(SECTORS_PER_ENTRY);
    localparam int BOUND_W = 33;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ENTRIES - 1);
    localparam logic [31:0]      RESET_BASE = 32'hFFFF_FFF0;
    localparam logic [31:0]      SPE_32     = 32'(SECTORS_PER_ENTRY);

    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic signed [SCORE_BITS+1:0] t_score_x;
    typedef logic signed [BOUND_W-1:0]    t_bound;

    localparam t_score_x SC_MAX_X    = {3'b000, {(SCORE_BITS-1){1'b1}}};
    localparam t_score_x SC_MIN_X    = {3'b111, {(SCORE_BITS-1){1'b0}}};
    localparam t_score_x MATCH_BONUS = t_score_x'(2);
    localparam t_bound   SEARCH_BOUND = t_bound'(33'sh0FFF_FFFF);

    typedef struct packed {
        logic             start;
        logic             scan;
        logic [IDX_W-1:0] idx;
        logic             finish;
    } t_dp_cmd;

    // saturating score add
    function automatic t_score sat_add(input t_score s, input t_score_x d);
        t_score_x r;
        r = t_score_x'(s) + d;
        if (r > SC_MAX_X) begin
            r = SC_MAX_X;
        end else if (r < SC_MIN_X) begin
            r = SC_MIN_X;
        end
        return t_score'(r);
    endfunction

    // entry*8 + offset, kept to 6 bits
    function automatic logic [5:0] slot_of(input logic [IDX_W-1:0] idx,
                                           input logic [OFF_W-1:0] off);
        logic [IDX_W+OFF_W+5:0] t;
        t = {6'b0, idx, off};
        return t[5:0];
    endfunction

    function automatic logic [2:0] entry_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] t;
        t = {3'b0, idx};
        return t[2:0];
    endfunction

endpackage

FILE: rtl/scsr_ctrl.sv
// Sequencer for the sector cache: request intake, entry scan, result commit.
// Depends on scsr_pkg.
module scsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output scsr_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic [scsr_pkg::IDX_W-1:0] r_idx;
    logic                      r_out_valid;
    logic                      w_accept;
    logic                      w_commit;

    assign w_accept = (r_state == S_IDLE) && i_s_tvalid;
    // result register free, or being drained this cycle
    assign w_commit = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    assign o_s_tready    = (r_state == S_IDLE);
    assign o_m_tvalid    = r_out_valid;
    assign o_cmd.start   = w_accept;
    assign o_cmd.scan    = (r_state == S_SCAN);
    assign o_cmd.idx     = r_idx;
    assign o_cmd.finish  = w_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == scsr_pkg::LAST_IDX) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("accepted request did not start a scan at entry zero");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && r_out_valid && !i_m_tready |=> (r_state == S_FIN))
        else $error("result committed over an undelivered one");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= scsr_pkg::LAST_IDX))
        else $error("scan index beyond last entry");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid && (r_state == S_IDLE))
        else $error("commit did not present a result");
`endif

endmodule

FILE: rtl/scsr_datapath.sv
// Tag/score storage, per-entry match and score update, victim tracking,
// counters and the result register. Depends on scsr_pkg.
module scsr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scsr_pkg::t_dp_cmd i_cmd,
    input  logic [31:0]       i_sector,
    output logic [111:0]      o_result
);

    logic [31:0]              r_base  [scsr_pkg::ENTRIES];
    scsr_pkg::t_score         r_score [scsr_pkg::ENTRIES];
    logic [31:0]              r_access;
    logic [31:0]              r_hits;
    logic [31:0]              r_sector;

    logic                       r_found;
    logic [scsr_pkg::IDX_W-1:0] r_found_idx;
    logic [scsr_pkg::OFF_W-1:0] r_found_off;
    logic [scsr_pkg::IDX_W-1:0] r_vic_idx;
    scsr_pkg::t_score           r_vic_score;
    scsr_pkg::t_bound           r_bound;
    logic [111:0]               r_result;

    logic [31:0]      w_base;
    logic [31:0]      w_top;
    logic [31:0]      w_diff;
    logic             w_match;
    scsr_pkg::t_score w_cur;
    scsr_pkg::t_score w_bumped;
    scsr_pkg::t_score w_new;
    scsr_pkg::t_bound w_new_b;
    logic [31:0]      n_access;
    logic [31:0]      n_hits;

    assign w_base  = r_base[i_cmd.idx];
    assign w_cur   = r_score[i_cmd.idx];
    assign w_top   = w_base + scsr_pkg::SPE_32;
    assign w_diff  = r_sector - w_base;
    assign w_match = (r_sector >= w_base) && (r_sector < w_top);

    always_comb begin
        w_bumped = (w_cur < 0) ? '0 : w_cur;
        w_bumped = scsr_pkg::sat_add(w_bumped, scsr_pkg::MATCH_BONUS);
        w_new    = scsr_pkg::sat_add(w_match ? w_bumped : w_cur, -scsr_pkg::t_score_x'(1));
    end

    assign w_new_b  = scsr_pkg::t_bound'(w_new);
    assign n_access = r_access + 32'd1;
    assign n_hits   = r_hits + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scsr_pkg::ENTRIES; i++) begin
                r_base[i]  <= scsr_pkg::RESET_BASE;
                r_score[i] <= '0;
            end
            r_access <= '0;
            r_hits   <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_score[i_cmd.idx] <= w_new;
            end
            if (i_cmd.finish) begin
                r_access <= n_access;
                if (r_found) begin
                    r_hits <= n_hits;
                end else begin
                    r_score[r_vic_idx] <= scsr_pkg::sat_add(r_vic_score,
                                                            scsr_pkg::t_score_x'(1));
                    r_base[r_vic_idx]  <= r_sector;
                end
            end
        end
    end

    // scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sector <= i_sector;
            r_found  <= 1'b0;
            r_bound  <= scsr_pkg::SEARCH_BOUND;
        end
        if (i_cmd.scan) begin
            if (w_match) begin
                r_found     <= 1'b1;
                r_found_idx <= i_cmd.idx;
                r_found_off <= w_diff[scsr_pkg::OFF_W-1:0];
            end
            // entry zero is the fallback victim even when not below the bound
            if (i_cmd.idx == '0 || w_new_b < r_bound) begin
                r_vic_idx   <= i_cmd.idx;
                r_vic_score <= w_new;
            end
            if (w_new_b < r_bound) begin
                r_bound <= w_new_b;
            end
        end
        if (i_cmd.finish) begin
            if (r_found) begin
                r_result <= {5'b0, n_hits, n_access, 32'd0, 1'b0,
                             scsr_pkg::slot_of(r_found_idx, r_found_off),
                             scsr_pkg::entry_of(r_found_idx), 1'b1};
            end else begin
                r_result <= {5'b0, r_hits, n_access, r_sector, 1'b1,
                             scsr_pkg::slot_of(r_vic_idx, '0),
                             scsr_pkg::entry_of(r_vic_idx), 1'b0};
            end
        end
    end

    assign o_result = r_result;

endmodule

FILE: rtl/sector_cache_score_replacement.sv
// Top level of the sector cache tag and replacement block: joins the
// sequencer and the datapath. Depends on scsr_pkg, scsr_ctrl, scsr_datapath.
//
//  channel | dir | tdata bits (low first)
//  --------+-----+-----------------------------------------------------------
//  s       | in  | [31:0] sector_number
//  m       | out | [0] hit, [3:1] entry_index, [9:4] slot_index,
//          |     | [10] fill_request, [42:11] fill_start_sector,
//          |     | [74:43] access_total, [106:75] hit_total, [111:107] zero
//
// A request is taken, then the single match/score unit walks the tags one
// entry after another, and then the result is committed.
// Reset restores all tags to 0xFFFFFFF0 and zeroes scores and counters at once.
// The result register lets the next request enter while a result waits;
// that request then holds in its commit step until the old result is taken.
module sector_cache_score_replacement (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // [31:0] sector_number
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata    // hit, entry_index, slot_index, fill_request,
                                      // fill_start_sector, access_total, hit_total
);

    scsr_pkg::t_dp_cmd w_cmd;

    scsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    scsr_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sector (i_s_tdata),
        .o_result (o_m_tdata)
    );

endmodule
